// ----- src/huffman_encoder_bit_packer_core_assert.svh -----
// Assertion macros shared by the encoder core modules.
`ifndef HUFFMAN_ENCODER_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_ENCODER_BIT_PACKER_CORE_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define HEBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define HEBP_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/hebp_pkg.sv -----
`timescale 1ns / 1ps

package hebp_pkg;

  // Field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned CODE_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BYTE_W = 8;
  // Pending bits are held left aligned; at most BYTE_W-1 of them
  localparam int unsigned PEND_W = 7;
  localparam int unsigned CNT_W  = 3;
  // Packing window: pending bits followed by one full code
  localparam int unsigned WIN_W  = PEND_W + CODE_W + 1;
  // Entries in the queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } out_item_t;

  // One code table entry
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_entry_t;

  // Work handed from front to back: a flush, or a left-aligned code
  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] code_la;
    logic [LEN_W-1:0]  len;
  } task_t;

endpackage

// ----- src/hebp_front.sv -----
`timescale 1ns / 1ps

module hebp_front #(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hebp_pkg::in_item_t in_data_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output hebp_pkg::task_t    push_data_o
);

  localparam int unsigned AW      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int unsigned LEN_CAP = (MAX_CODE_LEN < hebp_pkg::CODE_W) ?
                                    MAX_CODE_LEN : hebp_pkg::CODE_W;

  hebp_pkg::tbl_entry_t mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld_q;

  hebp_pkg::tbl_entry_t rd_q, wr_entry, entry;
  logic                 rd_vld_q;
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_flush_q;
  logic                 accept, sym_ok, s1_free, needs_push;
  logic                 is_load, is_encode, is_flush;
  logic [AW-1:0]        idx;
  logic [hebp_pkg::LEN_W-1:0]  len_c;
  logic [hebp_pkg::CODE_W-1:0] mask;

  // Classify the incoming beat
  assign accept    = in_valid_i && !in_stall_o;
  assign sym_ok    = {1'b0, in_data_i.symbol} < (hebp_pkg::SYM_W+1)'(SYMBOL_COUNT);
  assign idx       = in_data_i.symbol[AW-1:0];
  assign is_load   = in_data_i.opcode == hebp_pkg::OP_LOAD;
  assign is_encode = in_data_i.opcode == hebp_pkg::OP_ENCODE;
  assign is_flush  = in_data_i.opcode == hebp_pkg::OP_FLUSH;

  // Saturate the length and drop code bits above it
  always_comb begin
    if (in_data_i.code_length > hebp_pkg::LEN_W'(LEN_CAP)) begin
      len_c = hebp_pkg::LEN_W'(LEN_CAP);
    end else begin
      len_c = in_data_i.code_length;
    end
    mask          = ~({hebp_pkg::CODE_W{1'b1}} << len_c);
    wr_entry.code = in_data_i.code_bits & mask;
    wr_entry.len  = len_c;
  end

  // Code table: one write or one registered read per beat
  always_ff @(posedge clk_i) begin
    if (accept && sym_ok) begin
      if (is_load) begin
        mem[idx] <= wr_entry;
      end else if (is_encode) begin
        rd_q <= mem[idx];
      end
    end
  end

  // Entry valid bits stand in for clearing the table at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (accept && sym_ok) begin
      if (is_load) begin
        vld_q[idx] <= 1'b1;
      end else if (is_encode) begin
        rd_vld_q <= vld_q[idx];
      end
    end
  end

  // Stage register: decides whether the beat becomes back-end work
  assign entry       = rd_vld_q ? rd_q : '0;
  assign needs_push  = s1_flush_q || (entry.len != '0);
  assign push_valid_o = s1_valid_q && needs_push;
  assign s1_free     = !push_valid_o || push_ready_i;
  assign in_stall_o  = !s1_free;

  always_comb begin
    if (accept) begin
      s1_valid_d = (is_encode && sym_ok) || is_flush;
    end else if (s1_free) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        s1_flush_q <= is_flush;
      end
    end
  end

  // Left-align the code so the back end packs from the top
  always_comb begin
    push_data_o.is_flush = s1_flush_q;
    push_data_o.len      = entry.len;
    push_data_o.code_la  = entry.code << (hebp_pkg::LEN_W'(hebp_pkg::CODE_W) - entry.len);
  end

endmodule

// ----- src/hebp_fifo.sv -----
`timescale 1ns / 1ps

`include "huffman_encoder_bit_packer_core_assert.svh"

module hebp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  hebp_pkg::task_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output hebp_pkg::task_t pop_data_o
);

  localparam int unsigned DEPTH = hebp_pkg::QDEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  hebp_pkg::task_t   buf_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]    cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = cnt_q != (PTR_W+1)'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = buf_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  `HEBP_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= (PTR_W+1)'(DEPTH), "queue count overflow")
  `HEBP_ASSERT(a_cnt_step, clk_i, rst_ni, (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1), "queue count lost a push")

endmodule

// ----- src/hebp_back.sv -----
`timescale 1ns / 1ps

`include "huffman_encoder_bit_packer_core_assert.svh"

module hebp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  hebp_pkg::task_t     head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hebp_pkg::out_item_t out_data_o
);

  localparam int unsigned WIN_W  = hebp_pkg::WIN_W;
  localparam int unsigned BYTE_W = hebp_pkg::BYTE_W;
  localparam int unsigned PEND_W = hebp_pkg::PEND_W;
  localparam int unsigned CNT_W  = hebp_pkg::CNT_W;
  localparam int unsigned LEN_W  = hebp_pkg::LEN_W;

  logic [WIN_W-1:0]  win_q, win_d, win_h;
  logic [LEN_W-1:0]  rem_q, rem_d, tot_h;
  logic              busy_q, busy_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d, out_free, emit;
  hebp_pkg::out_item_t out_q, out_d;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Window for the queue head: pending bits, then the code right behind them
  assign win_h = {pend_q, {(WIN_W-PEND_W){1'b0}}} |
                 ({head_i.code_la, {(WIN_W-hebp_pkg::CODE_W){1'b0}}} >> cnt_q);
  assign tot_h = {{(LEN_W-CNT_W){1'b0}}, cnt_q} + head_i.len;

  // Packer: at most one byte per unstalled beat, from the busy window or the queue head
  always_comb begin
    win_d  = win_q;
    rem_d  = rem_q;
    busy_d = busy_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    pop_o  = 1'b0;
    emit   = 1'b0;
    out_d  = out_q;
    if (out_free) begin
      if (busy_q) begin
        emit              = 1'b1;
        out_d.out_byte    = win_q[WIN_W-1 -: BYTE_W];
        out_d.last_of_run = rem_q < LEN_W'(2*BYTE_W);
        win_d             = win_q << BYTE_W;
        rem_d             = rem_q - LEN_W'(BYTE_W);
        if (rem_q < LEN_W'(2*BYTE_W)) begin
          busy_d = 1'b0;
          pend_d = win_q[WIN_W-BYTE_W-1 -: PEND_W];
          cnt_d  = CNT_W'(rem_q - LEN_W'(BYTE_W));
        end
      end else if (head_valid_i) begin
        pop_o = 1'b1;
        if (head_i.is_flush) begin
          if (cnt_q != '0) begin
            emit              = 1'b1;
            out_d.out_byte    = {pend_q, 1'b0};
            out_d.last_of_run = 1'b1;
          end
          pend_d = '0;
          cnt_d  = '0;
        end else if (tot_h >= LEN_W'(BYTE_W)) begin
          emit              = 1'b1;
          out_d.out_byte    = win_h[WIN_W-1 -: BYTE_W];
          out_d.last_of_run = tot_h < LEN_W'(2*BYTE_W);
          if (tot_h >= LEN_W'(2*BYTE_W)) begin
            busy_d = 1'b1;
            win_d  = win_h << BYTE_W;
            rem_d  = tot_h - LEN_W'(BYTE_W);
          end else begin
            pend_d = win_h[WIN_W-BYTE_W-1 -: PEND_W];
            cnt_d  = CNT_W'(tot_h - LEN_W'(BYTE_W));
          end
        end else begin
          pend_d = win_h[WIN_W-1 -: PEND_W];
          cnt_d  = CNT_W'(tot_h);
        end
      end
    end
    out_valid_d = out_free ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Window and output beat carry no reset
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  `HEBP_ASSERT(a_busy_rem, clk_i, rst_ni, busy_q |-> (rem_q >= LEN_W'(BYTE_W)), "busy window holds less than a byte")
  `HEBP_ASSERT(a_pend_clean, clk_i, rst_ni, (pend_q & ({PEND_W{1'b1}} >> cnt_q)) == '0, "stray bits below pending count")
  `HEBP_NEVER(a_pop_busy, clk_i, rst_ni, pop_o && busy_q, "queue popped while a code is still packing")

endmodule

// ----- src/huffman_encoder_bit_packer_core.sv -----
`timescale 1ns / 1ps

// Huffman encoder with byte packer.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one item per unstalled beat:
//   load writes one code table entry, encode appends a symbol's code to the
//   pending bits, flush zero-pads and emits the pending partial byte.
// Output channel (out_valid_o / out_stall_i / out_data_o) gives at most one packed
//   byte per unstalled beat, earliest bit in the MSB; last_of_run marks the final byte of an item.
// An item's first byte passes the front stage, the queue and the output register.
// Throughput: the packer emits one byte per cycle while the output is not stalled;
//   an encode completes up to four bytes for a 32-bit code; loads and
//   zero-length encodes finish in the front stage.
// A two-entry queue sits between the table lookup and the packer, so the input
//   keeps flowing while the packer drains a long code.
// Reset marks all table entries invalid so they read as zero length, and empties the pending bits;
//   no clearing pass is needed, items are taken right after reset.
// When the receiver stalls, the output beat holds, the packer stops, the queue
//   fills and then in_stall_o rises.
module huffman_encoder_bit_packer_core #(
  parameter int unsigned SYMBOL_COUNT = 256,
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hebp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hebp_pkg::out_item_t out_data_o
);

  logic            push_valid, push_ready, head_valid, pop;
  hebp_pkg::task_t push_data, head;

  hebp_front #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  hebp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (head_valid),
    .pop_i       (pop),
    .pop_data_o  (head)
  );

  hebp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
